>>> rtl/core/dvrt_pkg.sv
package dvrt_pkg;

  // Default number of table entries
  localparam int unsigned TableDepth = 32;

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned CostW  = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CountW = 6;

  // Saturation value of a path cost
  localparam logic [CostW-1:0] CostMax = '1;

  // Operation selector codes
  typedef enum logic [KindW-1:0] {
    KIND_LINK   = 3'd0,
    KIND_ADV    = 3'd1,
    KIND_EMIT   = 3'd2,
    KIND_LOOK   = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_ADV,
    ST_SCAN_REL,
    ST_SCAN_EMIT,
    ST_SCAN_LOOK,
    ST_APPEND,
    ST_REPLY
  } state_e;

  // One table entry as stored in the memory
  typedef struct packed {
    logic [IdW-1:0]   dest;
    logic [CostW-1:0] cost;
    logic [IdW-1:0]   hop;
  } entry_t;

endpackage

>>> rtl/core/distance_vector_route_table.sv
// Distance-vector route table for one router.
// Input channel (in_valid_i/in_ready_o) carries one operation per item:
// kind_i selects add link, merge advertised entry, make split-horizon
// advertisement, lookup, or read-and-clear status. Output channel
// (out_valid_o/out_ready_i) returns result items; last_o marks the final
// result of an item. Kinds 5 to 7 are accepted and return nothing.
// Entries live in one single-port-write memory with a registered read;
// lookup, merge and advertisement walk the used entries one per cycle.
// Status replies directly; add link appends, then replies; lookup and
// advertisement walk the table, then reply; a merge makes two passes
// (cost to the advertiser, then relaxation with write-back) and, when no
// entry matched its destination, appends one if the table has room.
// An advertisement streams one result per qualifying entry, one held back
// so the last can be flagged. After the final result is loaded the
// sequencer returns to idle, where it takes the next item.
// A new item may enter while the previous final result still waits in the
// output register. When the receiver stalls, the walk holds on the pending
// entry until the output register frees up. Reset empties the table (count 0)
// and clears the change mark; the memory itself is not cleared.
module distance_vector_route_table_core #(
  parameter int unsigned TABLE_DEPTH = dvrt_pkg::TableDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dvrt_pkg::KindW-1:0]   kind_i,
  input  logic [dvrt_pkg::IdW-1:0]     peer_i,
  input  logic [dvrt_pkg::IdW-1:0]     target_i,
  input  logic [dvrt_pkg::CostW-1:0]   metric_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dvrt_pkg::IdW-1:0]     out_dest_o,
  output logic [dvrt_pkg::CostW-1:0]   out_cost_o,
  output logic [dvrt_pkg::IdW-1:0]     out_hop_o,
  output logic                         valid_res_o,
  output logic                         last_o,
  output logic                         changed_o,
  output logic [dvrt_pkg::CountW-1:0]  entry_count_o,
  output logic                         overflow_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(TABLE_DEPTH);

  // Entry memory
  dvrt_pkg::entry_t mem [TABLE_DEPTH];
  dvrt_pkg::entry_t rd_data_q;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             mem_we;
  logic [IdxW-1:0]  mem_wa;
  dvrt_pkg::entry_t mem_wd;

  // Control state
  dvrt_pkg::state_e state_q, state_d;
  dvrt_pkg::kind_e  kind_q;
  logic [CntW-1:0]  used_q;
  logic             mark_q;
  logic [CntW-1:0]  rd_ptr_q;
  logic             dv_q, dv_d;
  logic             found_q;
  logic             ok_q;
  logic             buf_valid_q;
  logic             out_valid_q;

  // Item payload and working values
  logic [dvrt_pkg::IdW-1:0]   peer_q, target_q;
  logic [dvrt_pkg::CostW-1:0] metric_q;
  logic [IdxW-1:0]            proc_idx_q;
  logic [dvrt_pkg::CostW-1:0] adv_q, sum_q, sum_d;
  logic [dvrt_pkg::CostW:0]   sum_wide;
  logic [dvrt_pkg::IdW-1:0]   bdest_q, lk_hop_q;
  logic [dvrt_pkg::CostW-1:0] bcost_q, lk_cost_q;

  // Output register
  logic [dvrt_pkg::IdW-1:0]    out_dest_q, out_hop_q;
  logic [dvrt_pkg::CostW-1:0]  out_cost_q;
  logic                        out_vres_q, out_last_q, out_chg_q, out_ovf_q;
  logic [dvrt_pkg::CountW-1:0] out_cnt_q;

  // Result to load into the output register
  logic                        push;
  logic [dvrt_pkg::IdW-1:0]    res_dest, res_hop;
  logic [dvrt_pkg::CostW-1:0]  res_cost;
  logic                        res_vres, res_last, res_chg, res_ovf;

  // Walk control
  logic accept, can_push, scanning, more, scan_done;
  logic issue, consume, need_push, qualify;
  logic hit_dest, hit_peer, cheaper, full;

  assign accept    = in_valid_i && in_ready_o;
  assign can_push  = !out_valid_q || out_ready_i;
  assign scanning  = (state_q == dvrt_pkg::ST_SCAN_ADV) || (state_q == dvrt_pkg::ST_SCAN_REL) ||
                     (state_q == dvrt_pkg::ST_SCAN_EMIT) || (state_q == dvrt_pkg::ST_SCAN_LOOK);
  assign more      = rd_ptr_q < used_q;
  assign scan_done = !more && !dv_q;
  assign full      = used_q >= FullCount;

  assign hit_dest  = rd_data_q.dest == target_q;
  assign hit_peer  = rd_data_q.dest == peer_q;
  assign qualify   = (rd_data_q.dest != peer_q) && (rd_data_q.hop != peer_q);
  assign cheaper   = sum_q < rd_data_q.cost;
  assign need_push = (state_q == dvrt_pkg::ST_SCAN_EMIT) && qualify && buf_valid_q;
  assign consume   = dv_q && (!need_push || can_push);
  assign issue     = scanning && more && (!dv_q || consume);
  assign dv_d      = issue ? 1'b1 : (consume ? 1'b0 : dv_q);
  assign rd_en     = issue;
  assign rd_addr   = rd_ptr_q[IdxW-1:0];

  // Saturate the cost through the advertiser
  assign sum_wide = {1'b0, metric_q} + {1'b0, adv_q};
  assign sum_d    = sum_wide[dvrt_pkg::CostW] ? dvrt_pkg::CostMax
                                              : sum_wide[dvrt_pkg::CostW-1:0];

  assign in_ready_o = state_q == dvrt_pkg::ST_IDLE;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dvrt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            dvrt_pkg::KIND_LINK:   state_d = dvrt_pkg::ST_APPEND;
            dvrt_pkg::KIND_ADV:    state_d = dvrt_pkg::ST_SCAN_ADV;
            dvrt_pkg::KIND_EMIT:   state_d = dvrt_pkg::ST_SCAN_EMIT;
            dvrt_pkg::KIND_LOOK:   state_d = dvrt_pkg::ST_SCAN_LOOK;
            dvrt_pkg::KIND_STATUS: state_d = dvrt_pkg::ST_REPLY;
            default:               state_d = dvrt_pkg::ST_IDLE;
          endcase
        end
      end
      dvrt_pkg::ST_SCAN_ADV: begin
        if (scan_done) state_d = dvrt_pkg::ST_SCAN_REL;
      end
      dvrt_pkg::ST_SCAN_REL: begin
        if (scan_done) state_d = found_q ? dvrt_pkg::ST_REPLY : dvrt_pkg::ST_APPEND;
      end
      dvrt_pkg::ST_SCAN_EMIT,
      dvrt_pkg::ST_SCAN_LOOK: begin
        if (scan_done) state_d = dvrt_pkg::ST_REPLY;
      end
      dvrt_pkg::ST_APPEND: state_d = dvrt_pkg::ST_REPLY;
      dvrt_pkg::ST_REPLY: begin
        if (can_push) state_d = dvrt_pkg::ST_IDLE;
      end
      default: state_d = dvrt_pkg::ST_IDLE;
    endcase
  end

  // Memory writes and result pushes
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = proc_idx_q;
    mem_wd   = '{dest: rd_data_q.dest, cost: sum_q, hop: peer_q};
    push     = 1'b0;
    res_dest = '0;
    res_cost = '0;
    res_hop  = '0;
    res_vres = 1'b0;
    res_last = 1'b1;
    res_chg  = 1'b0;
    res_ovf  = 1'b0;
    case (state_q)
      dvrt_pkg::ST_SCAN_REL: begin
        // lower a matching entry through the advertiser
        mem_we = consume && hit_dest && cheaper;
      end
      dvrt_pkg::ST_SCAN_EMIT: begin
        // release the held entry when a newer one qualifies
        push     = consume && need_push;
        res_dest = bdest_q;
        res_cost = bcost_q;
        res_vres = 1'b1;
        res_last = 1'b0;
      end
      dvrt_pkg::ST_APPEND: begin
        mem_we = !full;
        mem_wa = used_q[IdxW-1:0];
        if (kind_q == dvrt_pkg::KIND_LINK) begin
          mem_wd = '{dest: peer_q, cost: metric_q, hop: peer_q};
        end else begin
          mem_wd = '{dest: target_q, cost: sum_q, hop: peer_q};
        end
      end
      dvrt_pkg::ST_REPLY: begin
        push = can_push;
        case (kind_q)
          dvrt_pkg::KIND_LINK,
          dvrt_pkg::KIND_ADV: begin
            res_vres = ok_q;
            res_ovf  = !ok_q;
          end
          dvrt_pkg::KIND_EMIT: begin
            res_vres = buf_valid_q;
            if (buf_valid_q) begin
              res_dest = bdest_q;
              res_cost = bcost_q;
            end
          end
          dvrt_pkg::KIND_LOOK: begin
            res_vres = found_q;
            if (found_q) begin
              res_dest = target_q;
              res_cost = lk_cost_q;
              res_hop  = lk_hop_q;
            end
          end
          dvrt_pkg::KIND_STATUS: res_chg = mark_q;
          default: res_vres = 1'b0;
        endcase
      end
      default: push = 1'b0;
    endcase
  end

  // Entry memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dvrt_pkg::ST_IDLE;
      used_q      <= '0;
      mark_q      <= 1'b0;
      rd_ptr_q    <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      ok_q        <= 1'b0;
      buf_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= dv_d;
      if (accept) begin
        rd_ptr_q    <= '0;
        found_q     <= 1'b0;
        ok_q        <= 1'b1;
        buf_valid_q <= 1'b0;
      end
      // advance the walk
      if (issue) rd_ptr_q <= rd_ptr_q + 1'b1;
      // restart the walk for the relaxation pass
      if (state_q == dvrt_pkg::ST_SCAN_ADV && scan_done) rd_ptr_q <= '0;
      if (state_q == dvrt_pkg::ST_SCAN_REL && consume && hit_dest) begin
        found_q <= 1'b1;
        if (cheaper) mark_q <= 1'b1;
      end
      if (state_q == dvrt_pkg::ST_SCAN_LOOK && consume && hit_dest) found_q <= 1'b1;
      if (state_q == dvrt_pkg::ST_SCAN_EMIT && consume && qualify) buf_valid_q <= 1'b1;
      // append, or drop on a full table
      if (state_q == dvrt_pkg::ST_APPEND) begin
        if (full) begin
          ok_q <= 1'b0;
        end else begin
          used_q <= used_q + 1'b1;
          if (kind_q == dvrt_pkg::KIND_ADV) mark_q <= 1'b1;
        end
      end
      if (state_q == dvrt_pkg::ST_REPLY && can_push && kind_q == dvrt_pkg::KIND_STATUS) begin
        mark_q <= 1'b0;
      end
      // hold the result until taken
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= dvrt_pkg::kind_e'(kind_i);
      peer_q   <= peer_i;
      target_q <= target_i;
      metric_q <= metric_i;
      adv_q    <= '0;
    end
    if (issue) proc_idx_q <= rd_ptr_q[IdxW-1:0];
    // keep the cost of the last entry toward the advertiser
    if (state_q == dvrt_pkg::ST_SCAN_ADV && consume && hit_peer) adv_q <= rd_data_q.cost;
    if (state_q == dvrt_pkg::ST_SCAN_ADV && scan_done) sum_q <= sum_d;
    if (state_q == dvrt_pkg::ST_SCAN_EMIT && consume && qualify) begin
      bdest_q <= rd_data_q.dest;
      bcost_q <= rd_data_q.cost;
    end
    if (state_q == dvrt_pkg::ST_SCAN_LOOK && consume && hit_dest) begin
      lk_cost_q <= rd_data_q.cost;
      lk_hop_q  <= rd_data_q.hop;
    end
    if (push) begin
      out_dest_q <= res_dest;
      out_cost_q <= res_cost;
      out_hop_q  <= res_hop;
      out_vres_q <= res_vres;
      out_last_q <= res_last;
      out_chg_q  <= res_chg;
      out_ovf_q  <= res_ovf;
      out_cnt_q  <= dvrt_pkg::CountW'(used_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_dest_o    = out_dest_q;
  assign out_cost_o    = out_cost_q;
  assign out_hop_o     = out_hop_q;
  assign valid_res_o   = out_vres_q;
  assign last_o        = out_last_q;
  assign changed_o     = out_chg_q;
  assign entry_count_o = out_cnt_q;
  assign overflow_o    = out_ovf_q;

endmodule

>>> tb/distance_vector_route_table_core_tb.sv
module distance_vector_route_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomOps  = 447;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 2 * dvrt_pkg::TableDepth + 16;

  // Selector values that the block takes and ignores
  localparam logic [dvrt_pkg::KindW-1:0] KindSpareLo = 3'd5;
  localparam logic [dvrt_pkg::KindW-1:0] KindSpareHi = 3'd7;

  typedef struct packed {
    logic [dvrt_pkg::KindW-1:0] kind;
    logic [dvrt_pkg::IdW-1:0]   peer;
    logic [dvrt_pkg::IdW-1:0]   target;
    logic [dvrt_pkg::CostW-1:0] metric;
  } route_op_t;

  typedef struct packed {
    logic [dvrt_pkg::IdW-1:0]    dest;
    logic [dvrt_pkg::CostW-1:0]  cost;
    logic [dvrt_pkg::IdW-1:0]    hop;
    logic                        valid_res;
    logic                        last;
    logic                        changed;
    logic [dvrt_pkg::CountW-1:0] count;
    logic                        overflow;
  } route_reply_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [dvrt_pkg::KindW-1:0]  kind_i = '0;
  logic [dvrt_pkg::IdW-1:0]    peer_i = '0;
  logic [dvrt_pkg::IdW-1:0]    target_i = '0;
  logic [dvrt_pkg::CostW-1:0]  metric_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [dvrt_pkg::IdW-1:0]    out_dest_o;
  logic [dvrt_pkg::CostW-1:0]  out_cost_o;
  logic [dvrt_pkg::IdW-1:0]    out_hop_o;
  logic                        valid_res_o;
  logic                        last_o;
  logic                        changed_o;
  logic [dvrt_pkg::CountW-1:0] entry_count_o;
  logic                        overflow_o;

  distance_vector_route_table_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .peer_i       (peer_i),
    .target_i     (target_i),
    .metric_i     (metric_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_dest_o   (out_dest_o),
    .out_cost_o   (out_cost_o),
    .out_hop_o    (out_hop_o),
    .valid_res_o  (valid_res_o),
    .last_o       (last_o),
    .changed_o    (changed_o),
    .entry_count_o(entry_count_o),
    .overflow_o   (overflow_o)
  );

  // Pending operations and replies still owed by the block
  route_op_t    op_q[$];
  route_reply_t reply_q[$];
  int unsigned  err_cnt = 0;

  // Shadow route table
  logic [dvrt_pkg::IdW-1:0]   tbl_dest[dvrt_pkg::TableDepth];
  logic [dvrt_pkg::CostW-1:0] tbl_cost[dvrt_pkg::TableDepth];
  logic [dvrt_pkg::IdW-1:0]   tbl_hop[dvrt_pkg::TableDepth];
  int unsigned                tbl_used = 0;
  logic                       tbl_mark = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue a reply at the tail
  function automatic void queue_reply(route_reply_t r);
    reply_q.insert(reply_q.size(), r);
  endfunction

  function automatic void push_op(logic [dvrt_pkg::KindW-1:0] kind,
                                  logic [dvrt_pkg::IdW-1:0] peer,
                                  logic [dvrt_pkg::IdW-1:0] target,
                                  logic [dvrt_pkg::CostW-1:0] metric);
    route_op_t op;
    op.kind   = kind;
    op.peer   = peer;
    op.target = target;
    op.metric = metric;
    op_q.insert(op_q.size(), op);
  endfunction

  // Mostly a small set of node ids so entries collide, sometimes any id
  function automatic logic [dvrt_pkg::IdW-1:0] pick_id();
    logic [dvrt_pkg::IdW-1:0] v;
    if ($urandom_range(0, 7) == 0) return dvrt_pkg::IdW'($urandom_range(0, 255));
    v = dvrt_pkg::IdW'($urandom_range(0, 7));
    return (v < 6) ? v : 8'd248 + v;
  endfunction

  function automatic logic [dvrt_pkg::CostW-1:0] pick_metric();
    case ($urandom_range(0, 7))
      5:       return dvrt_pkg::CostW'($urandom_range(0, 1023));
      6:       return dvrt_pkg::CostW'($urandom_range(65000, 65535));
      7:       return dvrt_pkg::CostW'($urandom);
      default: return dvrt_pkg::CostW'($urandom_range(0, 63));
    endcase
  endfunction

  // Append an entry unless the table is full
  function automatic bit table_append(logic [dvrt_pkg::IdW-1:0] d,
                                      logic [dvrt_pkg::CostW-1:0] c,
                                      logic [dvrt_pkg::IdW-1:0] h);
    if (tbl_used >= dvrt_pkg::TableDepth) return 1'b0;
    tbl_dest[tbl_used] = d;
    tbl_cost[tbl_used] = c;
    tbl_hop[tbl_used]  = h;
    tbl_used++;
    return 1'b1;
  endfunction

  // Update the shadow table for one accepted operation and queue its replies
  function automatic void apply_route_op(route_op_t op);
    route_reply_t r;
    route_reply_t held;
    logic [dvrt_pkg::CostW:0]   sum;
    logic [dvrt_pkg::CostW-1:0] via;
    bit hit;
    bit ok;
    bit have;
    int at;
    r    = '0;
    held = '0;
    hit  = 1'b0;
    ok   = 1'b1;
    have = 1'b0;
    at   = 0;
    via  = '0;
    r.last = 1'b1;
    case (op.kind)
      dvrt_pkg::KIND_LINK: begin
        ok = table_append(op.peer, op.metric, op.peer);
        r.valid_res = ok;
        r.overflow  = !ok;
        r.count     = dvrt_pkg::CountW'(tbl_used);
        queue_reply(r);
      end
      dvrt_pkg::KIND_ADV: begin
        // cost to the advertiser comes from its last entry
        for (int i = 0; i < tbl_used; i++)
          if (tbl_dest[i] == op.peer) via = tbl_cost[i];
        sum = {1'b0, op.metric} + {1'b0, via};
        if (sum[dvrt_pkg::CostW]) sum = {1'b0, dvrt_pkg::CostMax};
        // relax every matching destination
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_dest[i] == op.target) begin
            hit = 1'b1;
            if (sum[dvrt_pkg::CostW-1:0] < tbl_cost[i]) begin
              tbl_cost[i] = sum[dvrt_pkg::CostW-1:0];
              tbl_hop[i]  = op.peer;
              tbl_mark    = 1'b1;
            end
          end
        end
        if (!hit) begin
          ok = table_append(op.target, sum[dvrt_pkg::CostW-1:0], op.peer);
          if (ok) tbl_mark = 1'b1;
        end
        r.valid_res = ok;
        r.overflow  = !ok;
        r.count     = dvrt_pkg::CountW'(tbl_used);
        queue_reply(r);
      end
      dvrt_pkg::KIND_EMIT: begin
        // hold one entry back so the final one can carry last
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_dest[i] != op.peer && tbl_hop[i] != op.peer) begin
            if (have) queue_reply(held);
            held           = '0;
            held.dest      = tbl_dest[i];
            held.cost      = tbl_cost[i];
            held.valid_res = 1'b1;
            held.count     = dvrt_pkg::CountW'(tbl_used);
            have           = 1'b1;
          end
        end
        if (have) begin
          held.last = 1'b1;
          queue_reply(held);
        end else begin
          r.count = dvrt_pkg::CountW'(tbl_used);
          queue_reply(r);
        end
      end
      dvrt_pkg::KIND_LOOK: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_dest[i] == op.target) begin
            hit = 1'b1;
            at  = i;
          end
        end
        if (hit) begin
          r.dest      = tbl_dest[at];
          r.cost      = tbl_cost[at];
          r.hop       = tbl_hop[at];
          r.valid_res = 1'b1;
        end
        r.count = dvrt_pkg::CountW'(tbl_used);
        queue_reply(r);
      end
      dvrt_pkg::KIND_STATUS: begin
        r.changed = tbl_mark;
        r.count   = dvrt_pkg::CountW'(tbl_used);
        tbl_mark  = 1'b0;
        queue_reply(r);
      end
      default: begin
        // spare selectors leave everything alone
      end
    endcase
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  // Driver: send items in bursts with random gaps
  route_op_t   drv_op;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= '0;
      peer_i     <= '0;
      target_i   <= '0;
      metric_i   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_route_op({kind_i, peer_i, target_i, metric_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (op_q.size() != 0) begin
          drv_op     = op_q.pop_front();
          kind_i     <= drv_op.kind;
          peer_i     <= drv_op.peer;
          target_i   <= drv_op.target;
          metric_i   <= drv_op.metric;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check replies, stall the output in changing modes
  int unsigned stall_mode;
  int unsigned mode_left;
  route_reply_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
      mode_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual dest %0h cost %0h last %0b",
                   $time, out_dest_o, out_cost_o, last_o);
          err_cnt++;
        end else begin
          want = reply_q.pop_front();
          check_field("out_dest", 32'(want.dest), 32'(out_dest_o));
          check_field("out_cost", 32'(want.cost), 32'(out_cost_o));
          check_field("out_hop", 32'(want.hop), 32'(out_hop_o));
          check_field("valid_res", 32'(want.valid_res), 32'(valid_res_o));
          check_field("last", 32'(want.last), 32'(last_o));
          check_field("changed", 32'(want.changed), 32'(changed_o));
          check_field("entry_count", 32'(want.count), 32'(entry_count_o));
          check_field("overflow", 32'(want.overflow), 32'(overflow_o));
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(4, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Stimulus, reset and end of run
  int unsigned cycles;
  int unsigned kept;
  int unsigned pick;

  initial begin
    cycles = 0;
    kept   = 0;
    rst_ni = 1'b0;

    // empty table: status, lookup miss, advertisement with nothing to send
    push_op(dvrt_pkg::KIND_STATUS, 8'd0, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_LOOK, 8'd0, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_EMIT, 8'd0, 8'd0, 16'd0);
    // links to ids 1 and 255 at the cost extremes, one destination twice
    push_op(dvrt_pkg::KIND_LINK, 8'd1, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_LINK, 8'd255, 8'd0, 16'hFFFF);
    push_op(dvrt_pkg::KIND_LINK, 8'd1, 8'd0, 16'd7);
    // merge that saturates and appends a new destination
    push_op(dvrt_pkg::KIND_ADV, 8'd1, 8'd0, 16'hFFFF);
    // unknown advertiser: cost through it is zero, relaxes the 255 entry
    push_op(dvrt_pkg::KIND_ADV, 8'd9, 8'd255, 16'd100);
    // merges that are not cheaper
    push_op(dvrt_pkg::KIND_ADV, 8'd255, 8'd1, 16'hFFFF);
    push_op(dvrt_pkg::KIND_ADV, 8'd1, 8'd1, 16'd0);
    // relax one of two matching entries
    push_op(dvrt_pkg::KIND_ADV, 8'd2, 8'd1, 16'd3);
    push_op(dvrt_pkg::KIND_LOOK, 8'd0, 8'd1, 16'd0);
    push_op(dvrt_pkg::KIND_LOOK, 8'd0, 8'd255, 16'd0);
    // split horizon on destination and on next hop
    push_op(dvrt_pkg::KIND_EMIT, 8'd1, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_EMIT, 8'd2, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_EMIT, 8'd77, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_STATUS, 8'd0, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_STATUS, 8'd0, 8'd0, 16'd0);
    push_op(dvrt_pkg::KIND_ADV, 8'd0, 8'd200, 16'hFFFF);
    push_op(dvrt_pkg::KIND_EMIT, 8'd255, 8'd0, 16'd0);
    // spare selectors
    push_op(KindSpareLo, 8'hA5, 8'h5A, 16'hA5A5);
    push_op(3'd6, 8'hFF, 8'hFF, 16'hFFFF);
    push_op(KindSpareHi, 8'h00, 8'h00, 16'h0000);

    // random part: the table grows, then fills and overflows
    while (kept < RandomOps) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        push_op(dvrt_pkg::KIND_LINK, pick_id(), pick_id(), pick_metric());
      end else if (pick < 45) begin
        push_op(dvrt_pkg::KIND_ADV, pick_id(), pick_id(), pick_metric());
      end else if (pick < 60) begin
        push_op(dvrt_pkg::KIND_EMIT, pick_id(), pick_id(), pick_metric());
      end else if (pick < 80) begin
        push_op(dvrt_pkg::KIND_LOOK, pick_id(), pick_id(), pick_metric());
      end else if (pick < 90) begin
        push_op(dvrt_pkg::KIND_STATUS, pick_id(), pick_id(), pick_metric());
      end else begin
        push_op(dvrt_pkg::KindW'($urandom_range(KindSpareLo, KindSpareHi)), pick_id(),
                pick_id(), pick_metric());
      end
      kept++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every item to go in and every reply to come back
    @(negedge clk_i);
    while (!(op_q.size() == 0 && !in_valid_i && reply_q.size() == 0) && cycles < CycleLimit) begin
      @(negedge clk_i);
      cycles++;
    end

    if (cycles >= CycleLimit) begin
      $display("distance_vector_route_table_core test failed");
    end else begin
      repeat (DrainCycles) @(negedge clk_i);
      if (err_cnt == 0 && reply_q.size() == 0) begin
        $display("distance_vector_route_table_core test passed");
      end else begin
        $display("distance_vector_route_table_core test failed");
      end
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dvrt_pkg.sv
rtl/core/distance_vector_route_table.sv
tb/distance_vector_route_table_core_tb.sv
